// File: hw/rtl/wsr_pkg.sv
// Package with the parser phases, opcodes and result kinds of the frame receiver.
`default_nettype none

package wsr_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT_HI  = 3'd2,
    PH_EXT_LO  = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_TEXT  = 2'd0;
  localparam kind_t KIND_PONG  = 2'd1;
  localparam kind_t KIND_CLOSE = 2'd2;
  localparam kind_t KIND_ERROR = 2'd3;

  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;
  localparam logic [7:0] PONG_HEADER = 8'h8A;
  localparam logic [3:0] OPCODE_MASK = 4'hF;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;

  // One result word: byte, kind and end-of-run flag.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

endpackage

`default_nettype wire

// File: hw/rtl/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: byte parser, unmasking and result queue.
`default_nettype none

// The receiver takes the incoming WebSocket byte stream one word at a time on the
// in_ channel and parses frames: opcode byte, length byte with the mask bit, an
// optional 16-bit big-endian extended length, four mask-key bytes when the mask bit
// is set, and then the payload. Text payload bytes (opcode 0x1) come out unmasked
// with tuser = 0. A ping (opcode 0x9) is answered with a pong frame on the out_
// channel (0x8A, the 7-bit length, then the unmasked payload) with tuser = 1. A
// close opcode gives one close word (tuser = 2); a 64-bit length or a ping longer
// than 125 bytes gives one error word (tuser = 3). After a close or an error every
// word is accepted and dropped until reset. tlast marks the final byte of a text
// message or pong frame and every event word. Each accepted byte is parsed in the
// cycle it arrives, so one byte is taken every clock while two queue slots are free;
// the ping length byte produces two result words and so needs two output slots.
// Results pass through a four-word queue, and in_tready stays high while at least
// two slots are free, so the input keeps flowing while a result waits downstream.
module websocket_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [1:0] kind
  output logic            out_tlast   // last_of_run
);
  import wsr_pkg::*;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_present_r, mask_present_nxt;
  logic [15:0] payload_length_r, payload_length_nxt;
  logic [15:0] byte_counter_r, byte_counter_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic        link_closed_r, link_closed_nxt;

  // Result queue.
  result_t            queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  logic        in_fire, out_fire;
  result_t     res0, res1;
  logic [1:0]  res_num;

  // Helper values for the parse.
  logic [6:0]  len7;
  logic [15:0] cnt_inc;
  logic [7:0]  key_byte;
  logic        pay_last;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  assign len7    = in_tdata[6:0];
  assign cnt_inc = byte_counter_r + 16'd1;

  always_comb begin
    case (byte_counter_r[1:0])
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // The incremented index reaches the length: 17-bit compare so a full counter works.
  assign pay_last = ({1'b0, byte_counter_r} + 17'd1) >= {1'b0, payload_length_r};

  always_comb begin
    phase_nxt          = phase_r;
    opcode_nxt         = opcode_r;
    mask_present_nxt   = mask_present_r;
    payload_length_nxt = payload_length_r;
    byte_counter_nxt   = byte_counter_r;
    mask_key_nxt       = mask_key_r;
    link_closed_nxt    = link_closed_r;
    res0               = '0;
    res1               = '0;
    res_num            = 2'd0;

    if (in_fire && !link_closed_r) begin
      case (phase_r)
        PH_LEN: begin
          mask_present_nxt = in_tdata[7];
          mask_key_nxt     = '0;
          if (len7 == LEN_EXT64 || (opcode_r == OP_PING && len7 == LEN_EXT16)) begin
            link_closed_nxt = 1'b1;
            phase_nxt       = PH_OPCODE;
            res0            = '{data: 8'h00, kind: KIND_ERROR, last: 1'b1};
            res_num         = 2'd1;
          end else if (len7 == LEN_EXT16) begin
            payload_length_nxt = '0;
            phase_nxt          = PH_EXT_HI;
          end else begin
            payload_length_nxt = {9'd0, len7};
            byte_counter_nxt   = '0;
            if (in_tdata[7]) begin
              phase_nxt = PH_MASK;
            end else begin
              phase_nxt = (len7 != 7'd0) ? PH_PAYLOAD : PH_OPCODE;
            end
            if (opcode_r == OP_PING) begin
              // Pong header goes out as soon as the ping length is known.
              res0    = '{data: PONG_HEADER, kind: KIND_PONG, last: 1'b0};
              res1    = '{data: {1'b0, len7}, kind: KIND_PONG, last: (len7 == 7'd0)};
              res_num = 2'd2;
            end
          end
        end
        PH_EXT_HI: begin
          payload_length_nxt = {in_tdata, 8'h00};
          phase_nxt          = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          payload_length_nxt = {payload_length_r[15:8], in_tdata};
          byte_counter_nxt   = '0;
          if (mask_present_r) begin
            phase_nxt = PH_MASK;
          end else begin
            phase_nxt = ({payload_length_r[15:8], in_tdata} != 16'd0) ? PH_PAYLOAD
                                                                       : PH_OPCODE;
          end
        end
        PH_MASK: begin
          mask_key_nxt     = {mask_key_r[23:0], in_tdata};
          byte_counter_nxt = cnt_inc;
          if (cnt_inc >= 16'd4) begin
            byte_counter_nxt = '0;
            phase_nxt        = (payload_length_r != 16'd0) ? PH_PAYLOAD : PH_OPCODE;
          end
        end
        PH_PAYLOAD: begin
          byte_counter_nxt = cnt_inc;
          if (pay_last) begin
            phase_nxt = PH_OPCODE;
          end
          if (opcode_r == OP_TEXT) begin
            res0    = '{data: in_tdata ^ key_byte, kind: KIND_TEXT, last: pay_last};
            res_num = 2'd1;
          end else if (opcode_r == OP_PING) begin
            res0    = '{data: in_tdata ^ key_byte, kind: KIND_PONG, last: pay_last};
            res_num = 2'd1;
          end
        end
        default: begin
          // Opcode byte; FIN and RSV bits are ignored. Unused phase codes land here too.
          opcode_nxt = in_tdata[3:0] & OPCODE_MASK;
          if ((in_tdata[3:0] & OPCODE_MASK) == OP_CLOSE) begin
            link_closed_nxt = 1'b1;
            phase_nxt       = PH_OPCODE;
            res0            = '{data: 8'h00, kind: KIND_CLOSE, last: 1'b1};
            res_num         = 2'd1;
          end else begin
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_OPCODE;
      opcode_r         <= '0;
      mask_present_r   <= 1'b0;
      payload_length_r <= '0;
      byte_counter_r   <= '0;
      mask_key_r       <= '0;
      link_closed_r    <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      opcode_r         <= opcode_nxt;
      mask_present_r   <= mask_present_nxt;
      payload_length_r <= payload_length_nxt;
      byte_counter_r   <= byte_counter_nxt;
      mask_key_r       <= mask_key_nxt;
      link_closed_r    <= link_closed_nxt;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign in_tready  = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = queue_r[rd_ptr_r].data;
  assign out_tuser  = queue_r[rd_ptr_r].kind;
  assign out_tlast  = queue_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (res_num != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (res_num == 2'd2) begin
      queue_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(res_num);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(res_num) - QCNT_W'(out_fire);
    end
  end

  // Checks on the parser and queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    link_closed_r |=> link_closed_r && $stable(phase_r))
    else $error("closed link left its dropped state");

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> byte_counter_r < payload_length_r)
    else $error("payload index ran past the frame length");

  assert property (@(posedge clk) disable iff (!rst_n)
    link_closed_r |-> res_num == 2'd0)
    else $error("result produced after close or error");

endmodule

`default_nettype wire
